[sv/mlfr_pkg.sv]
// shared constants, codes and beat types of the lcd frame store refresher
package mlfr_pkg;

  // panel geometry
  localparam int COLUMNS    = 128;
  localparam int PAGES      = 8;
  localparam int STORE_SIZE = COLUMNS * PAGES;
  localparam int HALF       = PAGES * 4;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int POS_W      = $clog2(COLUMNS + 3);

  // result queue
  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  // operation codes
  localparam logic [2:0] MODE_WRITE    = 3'd0;
  localparam logic [2:0] MODE_READ     = 3'd1;
  localparam logic [2:0] MODE_CLEAR    = 3'd2;
  localparam logic [2:0] MODE_REFRESH  = 3'd3;
  localparam logic [2:0] MODE_TICK     = 3'd4;
  localparam logic [2:0] MODE_CONTRAST = 3'd5;

  // result kinds
  localparam logic KIND_PANEL = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // panel commands and limits
  localparam logic [7:0] CMD_PAGE     = 8'hB0;
  localparam logic [7:0] CMD_COL_LO   = 8'h00;
  localparam logic [7:0] CMD_COL_HI   = 8'h10;
  localparam logic [7:0] CMD_RATIO    = 8'h20;
  localparam logic [7:0] CMD_CONTRAST = 8'h81;
  localparam int         RATIO_MAX    = 7;
  localparam int         CONTRAST_MAX = 63;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       colour;
    logic [7:0] ratio_in;
    logic [7:0] contrast_in;
  } in_beat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       is_data;
    logic       run_last;
    logic       pixel_value;
  } out_beat_t;

endpackage

[sv/mlfr_if.sv]
// valid/ready channel interfaces for input and result beats
interface mlfr_in_if;
  import mlfr_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mlfr_out_if;
  import mlfr_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/mlfr_ram.sv]
// generic single-port ram with registered read
module mlfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;
endmodule

[sv/mlfr_out_fifo.sv]
// small result queue that decouples the sequencer from the output channel
module mlfr_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mlfr_pkg::out_beat_t push_beat,
  output logic                room,
  mlfr_out_if.source          out_ch
);
  import mlfr_pkg::*;

  out_beat_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;

  assign pop            = out_ch.valid && out_ch.ready;
  assign out_ch.valid   = (cnt_r != '0);
  assign out_ch.payload = mem_r[rd_ptr_r];
  // room for a whole item's worth of results
  assign room           = (int'(cnt_r) <= FIFO_DEPTH - MAX_RESULTS);

  always_comb begin
    wr_ptr_nxt = push ? FIFO_PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? FIFO_PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = FIFO_CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = FIFO_CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_beat;
    end
  end
endmodule

[sv/mono_lcd_framebuffer_refresher_core.sv]
// page-addressed monochrome lcd frame store with panel refresh sequencer
//
//   channel  dir  handshake      carries
//   in_ch    in   valid/ready    one operation: pixel write/read, clear, refresh, tick, contrast
//   out_ch   out  valid/ready    one panel byte or one pixel read answer
//
// every item passes through accept and execute: the accept cycle issues the frame ram access,
// the next cycle consumes the registered read data (read-modify-write for pixel writes)
// contrast then goes on through S_CON2 and S_CON3, one per extra command beat
// clear then runs the clearing pass, one ram write per byte, and also restarts the refresh sequence
// after reset the same clearing pass runs before the first accept
// in_ch.ready drops outside idle and while the result queue has fewer than three free slots
module mono_lcd_framebuffer_refresher_core (
  input  logic        clk,
  input  logic        rst_n,
  mlfr_in_if.sink     in_ch,
  mlfr_out_if.source  out_ch
);
  import mlfr_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_CON2  = 5'b01000,
    S_CON3  = 5'b10000
  } state_t;

  // refresh positions of the page and low column commands and of the first data byte
  localparam int POS_PAGE_CMD = 0;
  localparam int POS_LO_CMD   = 1;
  localparam int POS_DATA     = 3;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // refresh sequencer
  logic [PAGE_W-1:0] ref_page_r, ref_page_nxt;
  logic [POS_W-1:0]  ref_pos_r, ref_pos_nxt;
  logic              ref_busy_r, ref_busy_nxt;

  // item held for the execute cycle
  logic [2:0]        op_r, op_nxt;
  logic              hit_r, hit_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              colour_r, colour_nxt;
  logic [2:0]        ratio_r, ratio_nxt;
  logic [5:0]        con_r, con_nxt;
  logic              tk_go_r, tk_go_nxt;
  logic              tk_data_r, tk_data_nxt;
  logic [7:0]        tk_cmd_r, tk_cmd_nxt;
  logic              tk_last_r, tk_last_nxt;

  // frame ram port
  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata, rmw_data;

  // result queue port
  logic              fifo_push, fifo_room;
  out_beat_t         fifo_beat;

  in_beat_t          ib;
  logic              in_fire;

  // pixel address decode
  logic              px_hit;
  logic [8:0]        px_row;
  logic [ADDR_W-1:0] px_addr;

  // refresh byte decode
  logic [COL_W-1:0]  tk_col;
  logic [ADDR_W-1:0] tk_addr;
  logic              tk_is_data, tk_lastcol, tk_lastall;
  logic [7:0]        tk_cmd;
  logic              tk_end;

  assign ib          = in_ch.payload;
  assign in_ch.ready = (state_r == S_IDLE) && fifo_room;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // coordinate mapping: upper half of y goes to the lower rows and vice versa
  always_comb begin
    px_hit = (ib.pixel_x != '0) && (int'(ib.pixel_x) <= COLUMNS) &&
             (ib.pixel_y != '0) && (int'(ib.pixel_y) <= 2 * HALF);
    if (int'(ib.pixel_y) <= HALF) begin
      px_row = 9'(int'(ib.pixel_y) + HALF - 1);
    end else begin
      px_row = 9'(int'(ib.pixel_y) - HALF - 1);
    end
    px_addr = ADDR_W'(int'(px_row >> 3) * COLUMNS + int'(ib.pixel_x) - 1);
  end

  // next refresh beat: three commands then the page's data bytes
  always_comb begin
    tk_col     = COL_W'(int'(ref_pos_r) - POS_DATA);
    tk_addr    = ADDR_W'(int'(ref_page_r) * COLUMNS + int'(tk_col));
    tk_is_data = (int'(ref_pos_r) >= POS_DATA);
    tk_lastcol = tk_is_data && (int'(tk_col) == COLUMNS - 1);
    tk_lastall = tk_lastcol && (int'(ref_page_r) == PAGES - 1);
    if (int'(ref_pos_r) == POS_PAGE_CMD) begin
      tk_cmd = CMD_PAGE | 8'(ref_page_r);
    end else if (int'(ref_pos_r) == POS_LO_CMD) begin
      tk_cmd = CMD_COL_LO;
    end else begin
      tk_cmd = CMD_COL_HI;
    end
  end

  assign tk_end = in_fire && (ib.mode == MODE_TICK) && ref_busy_r && tk_lastall;

  // pixel write merges the new bit into the byte just read
  always_comb begin
    rmw_data         = ram_rdata;
    rmw_data[bit_r]  = colour_r;
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    ref_page_nxt = ref_page_r;
    ref_pos_nxt  = ref_pos_r;
    ref_busy_nxt = ref_busy_r;
    op_nxt       = op_r;
    hit_nxt      = hit_r;
    bit_nxt      = bit_r;
    addr_nxt     = addr_r;
    colour_nxt   = colour_r;
    ratio_nxt    = ratio_r;
    con_nxt      = con_r;
    tk_go_nxt    = tk_go_r;
    tk_data_nxt  = tk_data_r;
    tk_cmd_nxt   = tk_cmd_r;
    tk_last_nxt  = tk_last_r;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = addr_r;
    ram_wdata    = rmw_data;
    fifo_push    = 1'b0;
    fifo_beat    = '{kind: KIND_PANEL, out_byte: '0, is_data: 1'b0,
                     run_last: 1'b0, pixel_value: 1'b0};

    unique case (state_r)
      S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_r;
        ram_wdata = '0;
        clr_cnt_nxt = ADDR_W'(clr_cnt_r + 1'b1);
        if (int'(clr_cnt_r) == STORE_SIZE - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_addr = (ib.mode == MODE_TICK) ? tk_addr : px_addr;
        if (in_fire) begin
          ram_en      = 1'b1;
          state_nxt   = S_EXEC;
          op_nxt      = ib.mode;
          hit_nxt     = px_hit;
          bit_nxt     = px_row[2:0];
          addr_nxt    = px_addr;
          colour_nxt  = ib.colour;
          ratio_nxt   = (int'(ib.ratio_in) > RATIO_MAX) ? 3'(RATIO_MAX) : ib.ratio_in[2:0];
          con_nxt     = (int'(ib.contrast_in) > CONTRAST_MAX) ? 6'(CONTRAST_MAX)
                                                             : ib.contrast_in[5:0];
          tk_go_nxt   = ref_busy_r;
          tk_data_nxt = tk_is_data;
          tk_cmd_nxt  = tk_cmd;
          tk_last_nxt = tk_lastall;
          case (ib.mode) inside
            MODE_CLEAR, MODE_REFRESH: begin
              ref_busy_nxt = 1'b1;
              ref_page_nxt = '0;
              ref_pos_nxt  = '0;
            end
            MODE_TICK: begin
              if (ref_busy_r) begin
                if (tk_lastall) begin
                  ref_busy_nxt = 1'b0;
                  ref_page_nxt = '0;
                  ref_pos_nxt  = '0;
                end else if (tk_lastcol) begin
                  ref_page_nxt = PAGE_W'(ref_page_r + 1'b1);
                  ref_pos_nxt  = '0;
                end else begin
                  ref_pos_nxt  = POS_W'(ref_pos_r + 1'b1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (op_r)
          MODE_WRITE: begin
            ram_en = hit_r;
            ram_we = hit_r;
          end
          MODE_READ: begin
            fifo_push             = 1'b1;
            fifo_beat.kind        = KIND_PIXEL;
            fifo_beat.pixel_value = hit_r && ram_rdata[bit_r];
          end
          MODE_CLEAR: begin
            clr_cnt_nxt = '0;
            state_nxt   = S_CLEAR;
          end
          MODE_TICK: begin
            fifo_push          = tk_go_r;
            fifo_beat.out_byte = tk_data_r ? ram_rdata : tk_cmd_r;
            fifo_beat.is_data  = tk_data_r;
            fifo_beat.run_last = tk_last_r;
          end
          MODE_CONTRAST: begin
            fifo_push          = 1'b1;
            fifo_beat.out_byte = CMD_RATIO | 8'(ratio_r);
            state_nxt          = S_CON2;
          end
          default: ;
        endcase
      end
      S_CON2: begin
        fifo_push          = 1'b1;
        fifo_beat.out_byte = CMD_CONTRAST;
        state_nxt          = S_CON3;
      end
      S_CON3: begin
        fifo_push          = 1'b1;
        fifo_beat.out_byte = 8'(con_r);
        fifo_beat.run_last = 1'b1;
        state_nxt          = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // control state; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      ref_page_r <= '0;
      ref_pos_r  <= '0;
      ref_busy_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      ref_page_r <= ref_page_nxt;
      ref_pos_r  <= ref_pos_nxt;
      ref_busy_r <= ref_busy_nxt;
    end
  end

  // held item fields
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    hit_r     <= hit_nxt;
    bit_r     <= bit_nxt;
    addr_r    <= addr_nxt;
    colour_r  <= colour_nxt;
    ratio_r   <= ratio_nxt;
    con_r     <= con_nxt;
    tk_go_r   <= tk_go_nxt;
    tk_data_r <= tk_data_nxt;
    tk_cmd_r  <= tk_cmd_nxt;
    tk_last_r <= tk_last_nxt;
  end

  mlfr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_frame_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  mlfr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_beat (fifo_beat),
    .room      (fifo_room),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // every accepted beat is followed by the execute cycle next
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_EXEC)
    else $error("accepted beat not followed by execute cycle");

  // refresh only ends on the last data byte of the last page
  a_refresh_end: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(ref_busy_r) |-> $past(tk_end))
    else $error("refresh ended without last data byte");

  // contrast run closes with a marked beat
  a_contrast_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CON3 |-> fifo_push && fifo_beat.run_last)
    else $error("contrast run not closed");

  // no item enters while the store is being cleared
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ch.ready && ram_we)
    else $error("beat accepted during clear");
`endif
endmodule
